[hw/rtl/gmat_pkg.sv]
package gmat_pkg;

  // configuration register map (word index taken from paddr[3:2])
  localparam int ADDR_W = 4;
  localparam logic [1:0] REG_WINDOW_LEN     = 2'd0;
  localparam logic [1:0] REG_XY_THRESHOLD   = 2'd1;
  localparam logic [1:0] REG_DIST_THRESHOLD = 2'd2;

  // register reset values
  localparam logic [4:0]  WINDOW_LEN_RST     = 5'd8;
  localparam logic [10:0] XY_THRESHOLD_RST   = 11'd40;
  localparam logic [14:0] DIST_THRESHOLD_RST = 15'd512;

  // accepted distance range, -8.0 .. 20.0 in Q8.8
  localparam logic signed [15:0] DIST_LO = -16'sd2048;
  localparam logic signed [15:0] DIST_HI = 16'sd5120;

  typedef struct packed {
    logic [4:0]  window_len;
    logic [10:0] xy_threshold;
    logic [14:0] dist_threshold;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SUM,
    ST_DIV,
    ST_EMIT
  } ctrl_state_e;

  // which result word the output register is loaded with
  typedef enum logic [1:0] {
    RES_EMPTY,
    RES_LAST,
    RES_HELD
  } res_sel_e;

  typedef struct packed {
    logic     latch_in;
    logic     clear;
    logic     gate;
    logic     sum_run;
    logic     div_start;
    logic     div_commit;
    logic     load_out;
    res_sel_e res_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic is_reject;
    logic has_history;
    logic sum_done;
    logic div_busy;
  } dp_status_t;

endpackage

[hw/rtl/gmat_if.sv]
// input word channel: one target sample or a clear command
interface gmat_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  logic signed [11:0] pos_x;
  logic signed [11:0] pos_y;
  logic signed [15:0] dist_req;

  modport source (output valid, op, pos_x, pos_y, dist_req, input ready);
  modport sink (input valid, op, pos_x, pos_y, dist_req, output ready);
endinterface

// result word channel
interface gmat_out_if;
  logic               valid;
  logic               ready;
  logic signed [19:0] avg_x;
  logic signed [19:0] avg_y;
  logic signed [15:0] dist_out;
  logic               no_estimate;
  logic               held;

  modport source (output valid, avg_x, avg_y, dist_out, no_estimate, held, input ready);
  modport sink (input valid, avg_x, avg_y, dist_out, no_estimate, held, output ready);
endinterface

[hw/rtl/gmat_div.sv]
module gmat_div #(
  parameter int DW = 24,
  parameter int VW = 5
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [VW-1:0] divisor_i,
  output logic          busy_o,
  output logic [DW-1:0] quotient_o
);

  localparam int CW = $clog2(DW + 1);

  logic [CW-1:0] cnt_q;
  logic          busy_q;
  logic [DW-1:0] quo_q, quo_d;
  logic [VW-1:0] rem_q, rem_d;
  logic [VW-1:0] dvs_q;
  logic [VW:0]   trial;
  logic          take;

  // one restoring step: bring down the next dividend bit
  always_comb begin
    trial = {rem_q, quo_q[DW-1]};
    take  = (trial >= {1'b0, dvs_q});
    rem_d = take ? VW'(trial - {1'b0, dvs_q}) : VW'(trial);
    quo_d = {quo_q[DW-2:0], take};
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CW'(DW);
      busy_q <= 1'b1;
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // quotient and remainder shift registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

[hw/rtl/gmat_dp.sv]
module gmat_dp #(
  parameter int MAX_WINDOW = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  gmat_pkg::cfg_t         cfg_i,
  input  gmat_pkg::dp_cmd_t      cmd_i,
  output gmat_pkg::dp_status_t   status_o,
  input  logic                   op_i,
  input  logic signed [11:0]     pos_x_i,
  input  logic signed [11:0]     pos_y_i,
  input  logic signed [15:0]     dist_req_i,
  output logic signed [19:0]     avg_x_o,
  output logic signed [19:0]     avg_y_o,
  output logic signed [15:0]     dist_out_o,
  output logic                   no_estimate_o,
  output logic                   held_o
);

  import gmat_pkg::*;

  localparam int PW = $clog2(MAX_WINDOW);
  localparam int FW = $clog2(MAX_WINDOW + 1);
  localparam int SW = 12 + PW;
  localparam int DW = SW + 8;

  // Q.8 to integer, truncated toward zero
  function automatic logic signed [12:0] trunc_q8(input logic signed [20:0] v);
    logic signed [20:0] s;
    s = v >>> 8;
    if (v[20] && (v[7:0] != 8'h00)) begin
      s = s + 21'sd1;
    end
    return 13'(s);
  endfunction

  // latched input word
  logic               op_q;
  logic signed [11:0] pos_x_q, pos_y_q;
  logic signed [15:0] dist_req_q;

  // history state
  logic [PW-1:0]      wp_q;
  logic [FW-1:0]      fill_q;
  logic signed [19:0] last_avg_x_q, last_avg_y_q;
  logic signed [15:0] last_dist_q;

  // ring memories and read port
  logic signed [11:0] ring_x_q [MAX_WINDOW];
  logic signed [11:0] ring_y_q [MAX_WINDOW];
  logic signed [11:0] rd_x_q, rd_y_q;
  logic [FW-1:0]      idx_q;
  logic               rd_valid_q;
  logic               rd_en;

  // accumulators and divider hookup
  logic signed [SW-1:0] sum_x_q, sum_y_q;
  logic                 neg_x_q, neg_y_q;
  logic [SW-1:0]        mag_x, mag_y;
  logic [DW-1:0]        quo_x, quo_y;
  logic                 busy_x, busy_y;

  // output register
  logic signed [19:0] avg_x_q, avg_y_q;
  logic signed [15:0] dist_out_q;
  logic               no_estimate_q, held_q;

  // window bookkeeping
  logic [FW-1:0] win, fill_clamp, fill_next;
  logic [PW-1:0] wp_eff, wp_next;

  // gating
  logic signed [20:0] thr_xy, ax, ay;
  logic signed [12:0] lo_x, hi_x, rep_x, lo_y, hi_y, rep_y, px13, py13;
  logic signed [17:0] thr_d, ld, pd18;
  logic signed [11:0] px_gated, py_gated;
  logic signed [15:0] pd_gated;

  // input latch
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      op_q       <= op_i;
      pos_x_q    <= pos_x_i;
      pos_y_q    <= pos_y_i;
      dist_req_q <= dist_req_i;
    end
  end

  // effective window, write position and fill level
  always_comb begin
    if (cfg_i.window_len == 5'd0) begin
      win = FW'(1);
    end else if (int'(cfg_i.window_len) > MAX_WINDOW) begin
      win = FW'(MAX_WINDOW);
    end else begin
      win = FW'(cfg_i.window_len);
    end
    fill_clamp = (fill_q > win) ? win : fill_q;
    fill_next  = (fill_clamp < win) ? fill_clamp + FW'(1) : win;
    wp_eff     = (FW'(wp_q) >= win) ? '0 : wp_q;
    wp_next    = ((FW'(wp_eff) + FW'(1)) >= win) ? '0 : wp_eff + PW'(1);
  end

  // gate x, y and distance against the last result
  always_comb begin
    thr_xy = $signed({2'b00, cfg_i.xy_threshold, 8'h00});
    ax     = 21'(last_avg_x_q);
    ay     = 21'(last_avg_y_q);
    lo_x   = trunc_q8(ax - thr_xy);
    hi_x   = trunc_q8(ax + thr_xy);
    rep_x  = trunc_q8(ax);
    lo_y   = trunc_q8(ay - thr_xy);
    hi_y   = trunc_q8(ay + thr_xy);
    rep_y  = trunc_q8(ay);
    px13   = 13'(pos_x_q);
    py13   = 13'(pos_y_q);
    thr_d  = $signed({3'b000, cfg_i.dist_threshold});
    ld     = 18'(last_dist_q);
    pd18   = 18'(dist_req_q);

    px_gated = pos_x_q;
    py_gated = pos_y_q;
    pd_gated = dist_req_q;
    if (fill_q != '0) begin
      if ((px13 < lo_x) || (px13 > hi_x)) begin
        px_gated = 12'(rep_x);
      end
      if ((py13 < lo_y) || (py13 > hi_y)) begin
        py_gated = 12'(rep_y);
      end
      if ((pd18 < (ld - thr_d)) || (pd18 > (ld + thr_d))) begin
        pd_gated = last_dist_q;
      end
    end
  end

  // history registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q         <= '0;
      fill_q       <= '0;
      last_avg_x_q <= '0;
      last_avg_y_q <= '0;
      last_dist_q  <= '0;
    end else if (cmd_i.clear) begin
      wp_q         <= '0;
      fill_q       <= '0;
      last_avg_x_q <= '0;
      last_avg_y_q <= '0;
      last_dist_q  <= '0;
    end else if (cmd_i.gate) begin
      wp_q        <= wp_next;
      fill_q      <= fill_next;
      last_dist_q <= pd_gated;
    end else if (cmd_i.div_commit) begin
      last_avg_x_q <= neg_x_q ? -$signed(20'(quo_x)) : $signed(20'(quo_x));
      last_avg_y_q <= neg_y_q ? -$signed(20'(quo_y)) : $signed(20'(quo_y));
    end
  end

  // read address sweep over the filled entries
  assign rd_en = cmd_i.sum_run && (idx_q != fill_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      rd_valid_q <= 1'b0;
    end else if (cmd_i.gate) begin
      idx_q      <= '0;
      rd_valid_q <= 1'b0;
    end else if (cmd_i.sum_run) begin
      rd_valid_q <= rd_en;
      if (rd_en) begin
        idx_q <= idx_q + FW'(1);
      end
    end
  end

  // ring memories: written on gating, read one entry a cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.gate) begin
      ring_x_q[wp_eff] <= px_gated;
      ring_y_q[wp_eff] <= py_gated;
    end
    if (rd_en) begin
      rd_x_q <= ring_x_q[idx_q[PW-1:0]];
      rd_y_q <= ring_y_q[idx_q[PW-1:0]];
    end
  end

  // accumulate the window sums
  always_ff @(posedge clk_i) begin
    if (cmd_i.gate) begin
      sum_x_q <= '0;
      sum_y_q <= '0;
    end else if (cmd_i.sum_run && rd_valid_q) begin
      sum_x_q <= sum_x_q + SW'(rd_x_q);
      sum_y_q <= sum_y_q + SW'(rd_y_q);
    end
  end

  // sign and magnitude for the unsigned dividers
  assign mag_x = $unsigned(sum_x_q[SW-1] ? -sum_x_q : sum_x_q);
  assign mag_y = $unsigned(sum_y_q[SW-1] ? -sum_y_q : sum_y_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      neg_x_q <= sum_x_q[SW-1];
      neg_y_q <= sum_y_q[SW-1];
    end
  end

  gmat_div #(
    .DW (DW),
    .VW (FW)
  ) u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i ({mag_x, 8'h00}),
    .divisor_i  (fill_q),
    .busy_o     (busy_x),
    .quotient_o (quo_x)
  );

  gmat_div #(
    .DW (DW),
    .VW (FW)
  ) u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i ({mag_y, 8'h00}),
    .divisor_i  (fill_q),
    .busy_o     (busy_y),
    .quotient_o (quo_y)
  );

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      case (cmd_i.res_sel)
        RES_EMPTY: begin
          avg_x_q       <= '0;
          avg_y_q       <= '0;
          dist_out_q    <= '0;
          no_estimate_q <= 1'b1;
          held_q        <= 1'b0;
        end
        RES_HELD: begin
          avg_x_q       <= last_avg_x_q;
          avg_y_q       <= last_avg_y_q;
          dist_out_q    <= last_dist_q;
          no_estimate_q <= 1'b0;
          held_q        <= 1'b1;
        end
        default: begin
          avg_x_q       <= last_avg_x_q;
          avg_y_q       <= last_avg_y_q;
          dist_out_q    <= last_dist_q;
          no_estimate_q <= 1'b0;
          held_q        <= 1'b0;
        end
      endcase
    end
  end

  // status towards the controller
  assign status_o.is_clear    = op_q;
  assign status_o.is_reject   = (dist_req_q < DIST_LO) || (dist_req_q > DIST_HI);
  assign status_o.has_history = (fill_q != '0);
  assign status_o.sum_done    = (idx_q == fill_q) && !rd_valid_q;
  assign status_o.div_busy    = busy_x || busy_y;

  assign avg_x_o       = avg_x_q;
  assign avg_y_o       = avg_y_q;
  assign dist_out_o    = dist_out_q;
  assign no_estimate_o = no_estimate_q;
  assign held_o        = held_q;

endmodule

[hw/rtl/gmat_ctrl.sv]
module gmat_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  gmat_pkg::dp_status_t status_i,
  output gmat_pkg::dp_cmd_t    cmd_o
);

  import gmat_pkg::*;

  ctrl_state_e state_q, state_d;
  res_sel_e    sel_q, sel_d;
  logic        out_valid_q, out_valid_d;

  // state, result select and output valid registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sel_q       <= RES_EMPTY;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    sel_d       = sel_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    cmd_o.res_sel = sel_q;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status_i.is_clear) begin
          cmd_o.clear = 1'b1;
          sel_d       = RES_EMPTY;
          state_d     = ST_EMIT;
        end else if (status_i.is_reject) begin
          sel_d   = status_i.has_history ? RES_HELD : RES_EMPTY;
          state_d = ST_EMIT;
        end else begin
          cmd_o.gate = 1'b1;
          sel_d      = RES_LAST;
          state_d    = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd_o.sum_run = 1'b1;
        if (status_i.sum_done) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!status_i.div_busy) begin
          cmd_o.div_commit = 1'b1;
          state_d          = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

  // a pending result word is never overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load_out && out_valid_q) |-> out_ready_i)
    else $error("result word overwritten before it was taken");

  // a loaded result is offered in the next cycle
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> out_valid_o)
    else $error("loaded result not offered");

  // one word at a time
  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second word taken while one is in work");

  // the dividers pick up a start
  a_div_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |=> status_i.div_busy)
    else $error("divider did not start");

endmodule

[hw/rtl/gated_moving_average_tracker_top.sv]
// Outlier-gated moving-average tracker. Each input word is a target sample
// (pos_x, pos_y, dist_req) or a clear command and yields exactly one result word.
// A sample whose distance lies outside -8.0 .. 20.0 (Q8.8) repeats the last result,
// or flags no estimate when there is no history; an accepted sample is gated
// against the last result, written into the ring, and the window mean of x and y
// (Q.8, truncated toward zero) is produced with the gated distance. Words are
// handled one at a time. A clear or a rejected sample goes from check straight to
// emit; an accepted sample is summed and then divided, the ring memory being summed
// one entry per cycle through its single read port over the fill entries averaged,
// and the bit-serial restoring dividers giving one quotient bit per cycle. The result
// sits in an output register, so the next word is taken while a result still waits.
// Registers on the APB port: window_len at 0x0, xy_threshold at 0x4, dist_threshold
// at 0x8; they are to be written only while the block is idle.
module gated_moving_average_tracker_top #(
  parameter int MAX_WINDOW = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gmat_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  gmat_in_if.sink                     in_i,
  gmat_out_if.source                  out_o
);

  import gmat_pkg::*;

  cfg_t       cfg_q;
  dp_cmd_t    cmd;
  dp_status_t status;
  logic       cfg_we;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.window_len     <= WINDOW_LEN_RST;
      cfg_q.xy_threshold   <= XY_THRESHOLD_RST;
      cfg_q.dist_threshold <= DIST_THRESHOLD_RST;
    end else if (cfg_we) begin
      case (paddr[3:2])
        REG_WINDOW_LEN:     cfg_q.window_len     <= pwdata[4:0];
        REG_XY_THRESHOLD:   cfg_q.xy_threshold   <= pwdata[10:0];
        REG_DIST_THRESHOLD: cfg_q.dist_threshold <= pwdata[14:0];
        default: begin
        end
      endcase
    end
  end

  // register read back
  always_comb begin
    case (paddr[3:2])
      REG_WINDOW_LEN:     prdata = 32'(cfg_q.window_len);
      REG_XY_THRESHOLD:   prdata = 32'(cfg_q.xy_threshold);
      REG_DIST_THRESHOLD: prdata = 32'(cfg_q.dist_threshold);
      default:            prdata = '0;
    endcase
  end

  // sequencer
  gmat_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // gating, ring, sums and dividers
  gmat_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .cmd_i         (cmd),
    .status_o      (status),
    .op_i          (in_i.op),
    .pos_x_i       (in_i.pos_x),
    .pos_y_i       (in_i.pos_y),
    .dist_req_i    (in_i.dist_req),
    .avg_x_o       (out_o.avg_x),
    .avg_y_o       (out_o.avg_y),
    .dist_out_o    (out_o.dist_out),
    .no_estimate_o (out_o.no_estimate),
    .held_o        (out_o.held)
  );

endmodule

[test/gmat_tb_pkg.sv]
package gmat_tb_pkg;

  // operation codes carried in the op field of an input word
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  // ring depth of the block as built for this bench
  localparam int MAX_WIN = 16;

  // one expected result word
  typedef struct packed {
    logic signed [19:0] avg_x;
    logic signed [19:0] avg_y;
    logic signed [15:0] dist_out;
    logic               no_estimate;
    logic               held;
  } est_t;

endpackage

[test/gmat_checker.sv]
module gmat_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [gmat_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  gmat_in_if                          in_w,
  gmat_out_if                         out_w,
  output int                          fail_count,
  output int                          words_pending
);
  import gmat_pkg::*;
  import gmat_tb_pkg::*;

  // shadow copy of the registers and the tracker state
  cfg_t               cfg;
  logic signed [11:0] trk_ring_x [MAX_WIN];
  logic signed [11:0] trk_ring_y [MAX_WIN];
  int                 wr_pos;
  int                 n_filled;
  int                 mean_x;
  int                 mean_y;
  int                 prev_dist;
  int                 errs;
  est_t               est_q [$];

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch: %s got %0d want %0d", $realtime, what, got, want);
    errs++;
  endtask

  function automatic void clear_track();
    wr_pos    = 0;
    n_filled  = 0;
    mean_x    = 0;
    mean_y    = 0;
    prev_dist = 0;
  endfunction

  // advance the tracker by one input word and return the result it yields
  function automatic est_t track_word(input logic op, input logic signed [11:0] x_in,
                                      input logic signed [11:0] y_in,
                                      input logic signed [15:0] d_in);
    est_t r;
    int   px;
    int   py;
    int   pd;
    int   thr;
    int   lo;
    int   hi;
    int   w;
    int   sx;
    int   sy;
    r  = '0;
    px = int'(x_in);
    py = int'(y_in);
    pd = int'(d_in);
    if (op == OP_CLEAR) begin
      clear_track();
      r.no_estimate = 1'b1;
      return r;
    end
    // distance outside the accepted range: nothing changes
    if (pd < int'(DIST_LO) || pd > int'(DIST_HI)) begin
      if (n_filled == 0) begin
        r.no_estimate = 1'b1;
      end else begin
        r.avg_x    = 20'(mean_x);
        r.avg_y    = 20'(mean_y);
        r.dist_out = 16'(prev_dist);
        r.held     = 1'b1;
      end
      return r;
    end
    w = int'(cfg.window_len);
    if (w == 0) w = 1;
    if (w > MAX_WIN) w = MAX_WIN;
    if (n_filled > w) n_filled = w;
    // gate each field against the previous result
    if (n_filled > 0) begin
      thr = int'(cfg.xy_threshold) * 256;
      lo  = (mean_x - thr) / 256;
      hi  = (mean_x + thr) / 256;
      if (px < lo || px > hi) px = mean_x / 256;
      lo  = (mean_y - thr) / 256;
      hi  = (mean_y + thr) / 256;
      if (py < lo || py > hi) py = mean_y / 256;
      thr = int'(cfg.dist_threshold);
      if (pd < prev_dist - thr || pd > prev_dist + thr) pd = prev_dist;
    end
    if (wr_pos >= w) wr_pos = 0;
    trk_ring_x[wr_pos] = px[11:0];
    trk_ring_y[wr_pos] = py[11:0];
    wr_pos = (wr_pos + 1 >= w) ? 0 : wr_pos + 1;
    if (n_filled < w) n_filled++;
    // window mean over the filled entries
    sx = 0;
    sy = 0;
    for (int i = 0; i < n_filled; i++) begin
      sx += int'(trk_ring_x[i]);
      sy += int'(trk_ring_y[i]);
    end
    mean_x     = (sx * 256) / n_filled;
    mean_y     = (sy * 256) / n_filled;
    prev_dist  = pd;
    r.avg_x    = 20'(mean_x);
    r.avg_y    = 20'(mean_y);
    r.dist_out = 16'(prev_dist);
    return r;
  endfunction

  // watch the register port and both word channels
  always @(posedge clk_i or negedge rst_ni) begin
    est_t want;
    if (!rst_ni) begin
      cfg.window_len     = WINDOW_LEN_RST;
      cfg.xy_threshold   = XY_THRESHOLD_RST;
      cfg.dist_threshold = DIST_THRESHOLD_RST;
      clear_track();
      est_q.delete();
      errs = 0;
      fail_count    <= 0;
      words_pending <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_WINDOW_LEN:     cfg.window_len     = pwdata[4:0];
          REG_XY_THRESHOLD:   cfg.xy_threshold   = pwdata[10:0];
          REG_DIST_THRESHOLD: cfg.dist_threshold = pwdata[14:0];
          default: ;
        endcase
      end
      if (in_w.valid && in_w.ready) begin
        est_q.push_back(track_word(in_w.op, in_w.pos_x, in_w.pos_y, in_w.dist_req));
      end
      if (out_w.valid && out_w.ready) begin
        if (est_q.size() == 0) begin
          report_mismatch("unexpected result word, avg_x", int'(out_w.avg_x), 0);
        end else begin
          want = est_q.pop_front();
          if (out_w.avg_x !== want.avg_x)
            report_mismatch("avg_x", int'(out_w.avg_x), int'(want.avg_x));
          if (out_w.avg_y !== want.avg_y)
            report_mismatch("avg_y", int'(out_w.avg_y), int'(want.avg_y));
          if (out_w.dist_out !== want.dist_out)
            report_mismatch("dist_out", int'(out_w.dist_out), int'(want.dist_out));
          if (out_w.no_estimate !== want.no_estimate)
            report_mismatch("no_estimate", int'(out_w.no_estimate), int'(want.no_estimate));
          if (out_w.held !== want.held)
            report_mismatch("held", int'(out_w.held), int'(want.held));
        end
      end
      fail_count    <= errs;
      words_pending <= est_q.size();
    end
  end

endmodule

[test/tb_top.sv]
module tb_top;
  import gmat_pkg::*;
  import gmat_tb_pkg::*;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;
  int                  fail_count;
  int                  words_pending;
  bit                  idle_en;
  int                  trail_x;
  int                  trail_y;
  int                  trail_d;

  gmat_in_if  in_ch ();
  gmat_out_if out_ch ();

  gated_moving_average_tracker_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_ch),
    .out_o   (out_ch)
  );

  gmat_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .in_w          (in_ch),
    .out_w         (out_ch),
    .fail_count    (fail_count),
    .words_pending (words_pending)
  );

  // clock
  always #5 clk_i = ~clk_i;

  // overall time limit
  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // result side back-pressure in random bursts
  initial begin
    out_ch.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (idle_en && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
    end
  end

  function automatic int clamp_int(input int v, input int lo, input int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // register write: setup cycle then access cycle
  task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // offer one input word, optionally after an idle burst, and wait for it to go
  task automatic send_word(input logic op, input int px, input int py, input int pd);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_ch.valid    <= 1'b1;
    in_ch.op       <= op;
    in_ch.pos_x    <= px[11:0];
    in_ch.pos_y    <= py[11:0];
    in_ch.dist_req <= pd[15:0];
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // stop offering words and let every expected result come out
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (words_pending != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
  endtask

  task automatic set_config(input int win, input int xy_thr, input int d_thr);
    drain();
    apb_write(REG_WINDOW_LEN, win);
    apb_write(REG_XY_THRESHOLD, xy_thr);
    apb_write(REG_DIST_THRESHOLD, d_thr);
  endtask

  // mostly samples that follow a wandering target, with outliers, rejects,
  // clears and raw noise mixed in
  task automatic send_random();
    int   roll;
    logic op;
    int   px;
    int   py;
    int   pd;
    roll    = $urandom_range(0, 99);
    op      = OP_SAMPLE;
    trail_x = clamp_int(trail_x + int'($urandom_range(0, 24)) - 12, -2048, 2047);
    trail_y = clamp_int(trail_y + int'($urandom_range(0, 24)) - 12, -2048, 2047);
    trail_d = clamp_int(trail_d + int'($urandom_range(0, 200)) - 100,
                        int'(DIST_LO), int'(DIST_HI));
    px = clamp_int(trail_x + int'($urandom_range(0, 8)) - 4, -2048, 2047);
    py = clamp_int(trail_y + int'($urandom_range(0, 8)) - 4, -2048, 2047);
    pd = clamp_int(trail_d + int'($urandom_range(0, 40)) - 20, int'(DIST_LO), int'(DIST_HI));
    if (roll < 3) begin
      op = OP_CLEAR;
    end else if (roll < 9) begin
      pd = $urandom_range(0, 1) ? int'($urandom_range(5121, 32767))
                                : -int'($urandom_range(2049, 32768));
    end else if (roll < 16) begin
      px = int'($urandom_range(0, 4095)) - 2048;
      py = int'($urandom_range(0, 4095)) - 2048;
      pd = int'($urandom_range(0, 65535)) - 32768;
    end else if (roll < 24) begin
      px = clamp_int(trail_x + ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(50, 2000)),
                     -2048, 2047);
      py = clamp_int(trail_y + ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(50, 2000)),
                     -2048, 2047);
      pd = clamp_int(trail_d + ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(600, 7000)),
                     int'(DIST_LO), int'(DIST_HI));
    end
    send_word(op, px, py, pd);
  endtask

  // stimulus
  initial begin
    idle_en        = 1'b1;
    trail_x        = 0;
    trail_y        = 0;
    trail_d        = 256;
    rst_ni         <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.op       <= OP_SAMPLE;
    in_ch.pos_x    <= '0;
    in_ch.pos_y    <= '0;
    in_ch.dist_req <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed words at the reset register values
    send_word(OP_SAMPLE, 0, 0, -32768);          // rejected, nothing tracked yet
    send_word(OP_SAMPLE, 2047, -2048, 32767);
    send_word(OP_CLEAR, 0, 0, 0);                // clear on empty history
    send_word(OP_SAMPLE, 2047, -2048, 5120);     // first sample, ungated, top of range
    send_word(OP_SAMPLE, -2048, 2047, -2048);    // every field gated out
    send_word(OP_SAMPLE, 0, 0, 5121);            // rejected, last result held
    send_word(OP_SAMPLE, 0, 0, -2049);
    send_word(OP_SAMPLE, 2007, -2008, 4608);     // right on the gate bounds
    send_word(OP_SAMPLE, 2006, -2007, 4607);     // just past the old bounds, inside the new ones
    for (int i = 0; i < 6; i++) begin
      send_word(OP_SAMPLE, 1990 - 10 * i, -1990 + 10 * i, 4000 - 100 * i);
    end
    send_word(OP_CLEAR, 0, 0, 0);
    send_word(OP_SAMPLE, 5, 5, 20000);           // rejected straight after a clear
    send_word(OP_SAMPLE, -2048, -2048, -2048);   // first after clear, ungated
    send_word(OP_CLEAR, -1, -1, -1);

    // phases over several register settings
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: set_config(16, 2047, 32767);
        1: set_config(1, 0, 0);
        2: set_config(0, 40, 512);
        3: set_config(31, 200, 1000);
        4: set_config(5, 2047, 0);
        5: set_config(16, 0, 32767);
        6: set_config(17 + $urandom_range(0, 14), $urandom_range(0, 2047), $urandom_range(0, 32767));
        default: set_config($urandom_range(0, 31), $urandom_range(0, 300), $urandom_range(0, 2000));
      endcase
      // fill the whole ring once so that no entry is ever read unwritten
      if (p == 0) begin
        send_word(OP_CLEAR, 0, 0, 0);
        for (int i = 0; i < MAX_WIN; i++) begin
          send_word(OP_SAMPLE, int'($urandom_range(0, 4095)) - 2048,
                    int'($urandom_range(0, 4095)) - 2048,
                    int'($urandom_range(0, 7168)) - 2048);
        end
      end
      if (p == 9) idle_en = 1'b0;
      for (int i = 0; i < 165; i++) begin
        send_random();
      end
    end

    drain();
    if (fail_count == 0 && words_pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/gmat_pkg.sv
hw/rtl/gmat_if.sv
hw/rtl/gmat_div.sv
hw/rtl/gmat_dp.sv
hw/rtl/gmat_ctrl.sv
hw/rtl/gated_moving_average_tracker_top.sv
test/gmat_tb_pkg.sv
test/gmat_checker.sv
test/tb_top.sv
